// ===== rtl/core/kdtsc_pkg.sv =====
// Shared types and constants for the key driven throttle and steer control.
// Holds field widths, key codes, operation codes, register indexes and the
// configuration struct. Depends on nothing.
package kdtsc_pkg;

   localparam int KEY_W      = 8;
   localparam int THR_W      = 11;
   localparam int STEER_W    = 8;
   localparam int STEP_W     = 7;
   localparam int LEVEL_W    = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [KEY_W-1:0] KEY_UP        = 8'h41;
   localparam logic [KEY_W-1:0] KEY_DOWN      = 8'h42;
   localparam logic [KEY_W-1:0] KEY_RIGHT     = 8'h43;
   localparam logic [KEY_W-1:0] KEY_LEFT      = 8'h44;
   localparam logic [KEY_W-1:0] KEY_SPACE     = 8'h20;
   localparam logic [KEY_W-1:0] KEY_CENTER_UC = 8'h4d;
   localparam logic [KEY_W-1:0] KEY_CENTER_LC = 8'h6d;
   localparam logic [KEY_W-1:0] KEY_TOGGLE_UC = 8'h51;
   localparam logic [KEY_W-1:0] KEY_TOGGLE_LC = 8'h71;

   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE_STEP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_STEP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_LEVEL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_LEVEL   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEVEL     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TURN      = 3'd5;

   typedef enum logic [2:0] {
      OP_LEFT,
      OP_RIGHT,
      OP_CENTER,
      OP_UP,
      OP_DOWN,
      OP_SPACE,
      OP_TOGGLE
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_entry_type;

   typedef struct packed {
      logic [STEP_W-1:0]  throttle_step;
      logic [STEP_W-1:0]  steer_step;
      logic [LEVEL_W-1:0] stop_level;
      logic [LEVEL_W-1:0] start_level;
      logic [LEVEL_W-1:0] max_level;
      logic [STEP_W-1:0]  max_turn;
   } config_type;

endpackage

// ===== rtl/core/kdtsc_if.sv =====
// Channel interfaces for the key driven throttle and steer control:
// key requests, result responses and configuration writes.
// Depends on kdtsc_pkg.
interface kdtsc_req_if;
   import kdtsc_pkg::*;
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_code;
   modport source (output valid, output key_code, input ready);
   modport sink (input valid, input key_code, output ready);
endinterface

interface kdtsc_rsp_if;
   import kdtsc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [THR_W-1:0]   throttle_out;
   logic signed [STEER_W-1:0] steer_out;
   logic                      kick;
   logic                      moving_now;
   logic                      forward_now;
   logic                      last;
   modport source (output valid, output throttle_out, output steer_out, output kick,
                   output moving_now, output forward_now, output last, input ready);
   modport sink (input valid, input throttle_out, input steer_out, input kick,
                 input moving_now, input forward_now, input last, output ready);
endinterface

interface kdtsc_csr_if;
   import kdtsc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/kdtsc_front.sv =====
// Front stage: accepts key transfers, decodes them into operations and
// pushes known operations toward the queue. Depends on kdtsc_pkg, kdtsc_if.
module kdtsc_front (
   input  logic                        clock,
   input  logic                        reset,
   kdtsc_req_if.sink                   req_chan,
   output kdtsc_pkg::queue_entry_type  push,
   input  logic                        push_ready
);
   import kdtsc_pkg::*;

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   known;
   op_type decoded;

   always_comb begin
      known   = 1'b1;
      decoded = OP_LEFT;
      case (req_chan.key_code)
         KEY_LEFT:      decoded = OP_LEFT;
         KEY_RIGHT:     decoded = OP_RIGHT;
         KEY_CENTER_UC: decoded = OP_CENTER;
         KEY_CENTER_LC: decoded = OP_CENTER;
         KEY_UP:        decoded = OP_UP;
         KEY_DOWN:      decoded = OP_DOWN;
         KEY_SPACE:     decoded = OP_SPACE;
         KEY_TOGGLE_UC: decoded = OP_TOGGLE;
         KEY_TOGGLE_LC: decoded = OP_TOGGLE;
         default:       known   = 1'b0;
      endcase
   end

   assign req_chan.ready = !valid_ff || push_ready;

   always_comb begin
      valid_in = valid_ff;
      op_in    = op_ff;
      if (req_chan.valid && req_chan.ready) begin
         // Unknown keys are dropped here and never reach the queue.
         valid_in = known;
         op_in    = decoded;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   assign push.valid = valid_ff;
   assign push.op    = op_ff;

endmodule

// ===== rtl/core/kdtsc_queue.sv =====
// Short operation queue between the front and back stages.
// Depends on kdtsc_pkg.
module kdtsc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  kdtsc_pkg::queue_entry_type  push,
   output logic                        push_ready,
   output kdtsc_pkg::queue_entry_type  head,
   input  logic                        pop
);
   import kdtsc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.op    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

// ===== rtl/core/kdtsc_back.sv =====
// Back stage: executes queued operations on the throttle, steer and flag
// state and drives the registered result channel. Depends on kdtsc_pkg, kdtsc_if.
module kdtsc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  kdtsc_pkg::queue_entry_type  head,
   output logic                        pop,
   input  kdtsc_pkg::config_type       cfg,
   kdtsc_rsp_if.source                 rsp_chan
);
   import kdtsc_pkg::*;

   localparam int TW = THR_W + 2;
   localparam int SW = STEER_W + 2;
   localparam logic signed [TW-1:0] THR_LO   = TW'(-(2 ** (THR_W - 1)));
   localparam logic signed [TW-1:0] THR_HI   = TW'(2 ** (THR_W - 1) - 1);
   localparam logic signed [SW-1:0] STEER_LO = SW'(-(2 ** (STEER_W - 1)));
   localparam logic signed [SW-1:0] STEER_HI = SW'(2 ** (STEER_W - 1) - 1);

   function automatic logic signed [THR_W-1:0] sat_thr(input logic signed [TW-1:0] v);
      logic signed [TW-1:0] r;
      r = (v < THR_LO) ? THR_LO : ((v > THR_HI) ? THR_HI : v);
      return r[THR_W-1:0];
   endfunction

   function automatic logic signed [STEER_W-1:0] sat_st(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = (v < STEER_LO) ? STEER_LO : ((v > STEER_HI) ? STEER_HI : v);
      return r[STEER_W-1:0];
   endfunction

   logic signed [THR_W-1:0]   throttle_ff, throttle_in;
   logic signed [STEER_W-1:0] steer_ff, steer_in;
   logic                      moving_ff, moving_in;
   logic                      forward_ff, forward_in;
   logic                      phase_ff;
   logic                      out_valid_ff;
   logic signed [THR_W-1:0]   out_thr_ff;
   logic signed [STEER_W-1:0] out_steer_ff;
   logic                      out_kick_ff, out_moving_ff, out_forward_ff, out_last_ff;

   logic signed [TW-1:0] thr_w, ts_w, stp_w, sta_w, mx_w, t_tmp;
   logic signed [SW-1:0] st_w, ss_w, mt_w, s_tmp;
   logic signed [THR_W-1:0] res_thr;
   logic res_kick, res_last, has_res, start, can_load, fire;

   always_comb begin
      thr_w = TW'(throttle_ff);
      ts_w  = $signed({{(TW - STEP_W){1'b0}}, cfg.throttle_step});
      stp_w = $signed({{(TW - LEVEL_W){1'b0}}, cfg.stop_level});
      sta_w = $signed({{(TW - LEVEL_W){1'b0}}, cfg.start_level});
      mx_w  = $signed({{(TW - LEVEL_W){1'b0}}, cfg.max_level});
      st_w  = SW'(steer_ff);
      ss_w  = $signed({{(SW - STEP_W){1'b0}}, cfg.steer_step});
      mt_w  = $signed({{(SW - STEP_W){1'b0}}, cfg.max_turn});

      throttle_in = throttle_ff;
      steer_in    = steer_ff;
      moving_in   = moving_ff;
      forward_in  = forward_ff;
      res_thr     = throttle_ff;
      res_kick    = 1'b0;
      res_last    = 1'b1;
      has_res     = 1'b1;
      start       = 1'b0;
      t_tmp       = '0;
      s_tmp       = '0;

      case (head.op)
         OP_LEFT: begin
            s_tmp    = st_w - ss_w;
            steer_in = sat_st((s_tmp < -mt_w) ? -mt_w : s_tmp);
         end
         OP_RIGHT: begin
            s_tmp    = st_w + ss_w;
            steer_in = sat_st((s_tmp > mt_w) ? mt_w : s_tmp);
         end
         OP_CENTER: begin
            steer_in = '0;
         end
         OP_UP: begin
            if (!moving_ff) begin
               has_res = 1'b0;
            end else begin
               // The reverse test comes first, so a zero stop level sends a
               // zero throttle down the reverse branch.
               if (thr_w <= -stp_w) begin
                  t_tmp = thr_w - ts_w;
                  t_tmp = (t_tmp < -mx_w) ? -mx_w : t_tmp;
               end else if (thr_w >= stp_w) begin
                  t_tmp = thr_w + ts_w;
                  t_tmp = (t_tmp > mx_w) ? mx_w : t_tmp;
               end else begin
                  t_tmp = '0;
               end
               throttle_in = sat_thr(t_tmp);
               res_thr     = throttle_in;
            end
         end
         OP_DOWN: begin
            if (thr_w >= stp_w) begin
               t_tmp = thr_w - ts_w;
               t_tmp = (t_tmp < stp_w) ? stp_w : t_tmp;
            end else if (thr_w <= -stp_w) begin
               t_tmp = thr_w + ts_w;
               t_tmp = (t_tmp > -stp_w) ? -stp_w : t_tmp;
            end else begin
               t_tmp = '0;
            end
            throttle_in = sat_thr(t_tmp);
            res_thr     = throttle_in;
         end
         OP_SPACE: begin
            if (moving_ff) begin
               throttle_in = '0;
               moving_in   = 1'b0;
               res_thr     = '0;
            end else begin
               start       = 1'b1;
               moving_in   = 1'b1;
               throttle_in = sat_thr(forward_ff ? stp_w : -stp_w);
               if (!phase_ff) begin
                  res_thr  = sat_thr(forward_ff ? sta_w : -sta_w);
                  res_kick = 1'b1;
                  res_last = 1'b0;
               end else begin
                  res_thr = throttle_in;
               end
            end
         end
         OP_TOGGLE: begin
            has_res = 1'b0;
            if (!moving_ff) begin
               forward_in = !forward_ff;
            end
         end
         default: begin
            has_res = 1'b0;
         end
      endcase
   end

   assign can_load = !out_valid_ff || rsp_chan.ready;
   assign fire     = head.valid && (!has_res || can_load);
   // A start holds its operation at the head for a second result.
   assign pop      = fire && !(start && !phase_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_ff  <= '0;
         steer_ff     <= '0;
         moving_ff    <= 1'b0;
         forward_ff   <= 1'b1;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            throttle_ff <= throttle_in;
            steer_ff    <= steer_in;
            moving_ff   <= moving_in;
            forward_ff  <= forward_in;
            phase_ff    <= 1'b0;
         end else if (fire) begin
            phase_ff <= 1'b1;
         end
         if (fire && has_res) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && has_res) begin
         out_thr_ff     <= res_thr;
         out_steer_ff   <= steer_in;
         out_kick_ff    <= res_kick;
         out_moving_ff  <= moving_in;
         out_forward_ff <= forward_in;
         out_last_ff    <= res_last;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.throttle_out = out_thr_ff;
   assign rsp_chan.steer_out    = out_steer_ff;
   assign rsp_chan.kick         = out_kick_ff;
   assign rsp_chan.moving_now   = out_moving_ff;
   assign rsp_chan.forward_now  = out_forward_ff;
   assign rsp_chan.last         = out_last_ff;

endmodule

// ===== rtl/core/key_driven_throttle_steer_control.sv =====
// Top level of the key driven throttle and steer control: configuration
// registers, front decode stage, operation queue and back execution stage.
// Depends on kdtsc_pkg, kdtsc_if, kdtsc_front, kdtsc_queue and kdtsc_back.
//
// Usage: each transfer on req_chan carries one raw key byte. Arrow keys steer
// and change the throttle, space stops or starts the car, m/M centers the
// steer and q/Q flips direction while stopped. Unknown keys are dropped.
// Each key gives zero, one or two transfers on rsp_chan; the last flag marks
// the final result of a key. A start gives a kick result followed by a hold
// result.
// Path: a key passes the front register, the queue and the result register
// before its first result is valid. Throughput is one key per cycle while the
// result side is ready; a start holds the head of the queue in the back stage
// because it owns the result register for two transfers. The front stage and
// the queue let keys keep flowing while a result waits; when the receiver stalls
// the result register holds, the queue fills and then req_chan.ready drops.
// csr_chan is always ready and writes register csr_chan.index; it should be
// written only while no key is in flight.
// Reset clears the queue, the pending result, throttle and steer to zero,
// the car to stopped and forward, and the registers to their defaults.
module key_driven_throttle_steer_control #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   kdtsc_req_if.sink   req_chan,
   kdtsc_rsp_if.source rsp_chan,
   kdtsc_csr_if.sink   csr_chan
);
   import kdtsc_pkg::*;

   config_type      cfg_ff;
   queue_entry_type push;
   queue_entry_type head;
   logic            push_ready;
   logic            pop;

   // Register writes are always taken; indexes beyond the list are ignored.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_step <= 7'd1;
         cfg_ff.steer_step    <= 7'd5;
         cfg_ff.stop_level    <= 10'd60;
         cfg_ff.start_level   <= 10'd95;
         cfg_ff.max_level     <= 10'd150;
         cfg_ff.max_turn      <= 7'd100;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_THROTTLE_STEP: cfg_ff.throttle_step <= csr_chan.data[STEP_W-1:0];
            CSR_STEER_STEP:    cfg_ff.steer_step    <= csr_chan.data[STEP_W-1:0];
            CSR_STOP_LEVEL:    cfg_ff.stop_level    <= csr_chan.data[LEVEL_W-1:0];
            CSR_START_LEVEL:   cfg_ff.start_level   <= csr_chan.data[LEVEL_W-1:0];
            CSR_MAX_LEVEL:     cfg_ff.max_level     <= csr_chan.data[LEVEL_W-1:0];
            CSR_MAX_TURN:      cfg_ff.max_turn      <= csr_chan.data[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   kdtsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push       (push),
      .push_ready (push_ready)
   );

   kdtsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   kdtsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .cfg      (cfg_ff),
      .rsp_chan (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // A kick transfer is followed at once by the hold result of the same start.
   a_kick_then_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last)
      |=> (rsp_chan.valid && rsp_chan.last && !rsp_chan.kick && rsp_chan.moving_now))
      else $error("start kick not followed by its hold result");

   // A kick only comes from a start, which leaves the car moving.
   a_kick_moving: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kick) |-> (rsp_chan.moving_now && !rsp_chan.last))
      else $error("kick result with wrong flags");

   // The back stage only consumes what the queue holds.
   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("queue popped while empty");
`endif

endmodule
